// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer package
// Shared constants, register codes and the types that pass between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

   localparam int COUNTER_SLOTS = 16;
   localparam int SLOT_W        = $clog2(COUNTER_SLOTS);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W        = 4;
   localparam int DATA_W        = 32;

   localparam logic [7:0] SYNC_BYTE     = 8'h47;
   localparam logic [7:0] POINTER_BYTE  = 8'h00;
   localparam logic [7:0] PAD_BYTE      = 8'hFF;
   localparam logic [7:0] PAYLOAD_BYTES = 8'd184;
   localparam logic [1:0] SCRAMBLE_BITS = 2'b00;

   localparam logic [1:0] REG_PACKET_ID     = 2'd0;
   localparam logic [1:0] REG_PRIORITY_BIT  = 2'd1;
   localparam logic [1:0] REG_FIELD_CONTROL = 2'd2;

   localparam logic [12:0] PACKET_ID_RESET     = 13'd0;
   localparam logic        PRIORITY_BIT_RESET  = 1'b0;
   localparam logic [1:0]  FIELD_CONTROL_RESET = 2'd1;

   typedef struct packed {
      logic [12:0] packet_id;
      logic        priority_bit;
      logic [1:0]  field_control;
   } cfg_type;

   // One accepted transaction, classified by the front part.
   typedef struct packed {
      logic       hdr;
      logic       start;
      logic       ptr;
      logic [3:0] cc;
      logic [7:0] data;
      logic       eop;
      logic       pad;
      logic [7:0] rep;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== rtl/tsp_csr.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer register file
// Holds the PID, priority and adaptation field control registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [tsp_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [tsp_pkg::DATA_W-1:0]   pwdata,
   output logic      [tsp_pkg::DATA_W-1:0]   prdata,
   output logic                              pready,
   output tsp_pkg::cfg_type                  cfg
);

   tsp_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_id     <= tsp_pkg::PACKET_ID_RESET;
         cfg_ff.priority_bit  <= tsp_pkg::PRIORITY_BIT_RESET;
         cfg_ff.field_control <= tsp_pkg::FIELD_CONTROL_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tsp_pkg::REG_PACKET_ID:     cfg_ff.packet_id     <= pwdata[12:0];
            tsp_pkg::REG_PRIORITY_BIT:  cfg_ff.priority_bit  <= pwdata[0];
            tsp_pkg::REG_FIELD_CONTROL: cfg_ff.field_control <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         tsp_pkg::REG_PACKET_ID:     prdata[12:0] = cfg_ff.packet_id;
         tsp_pkg::REG_PRIORITY_BIT:  prdata[0]    = cfg_ff.priority_bit;
         tsp_pkg::REG_FIELD_CONTROL: prdata[1:0]  = cfg_ff.field_control;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tsp_front.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer front part
// Accepts section bytes, tracks packet position and continuity counters, and
// classifies each transaction into a descriptor for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [3:0]          req_counter_slot,
   input  wire logic [7:0]          req_section_byte,
   input  wire logic                req_first_of_section,
   input  wire logic                req_last_of_section,
   input  wire tsp_pkg::qstat_type  qstat,
   output logic                     push,
   output tsp_pkg::desc_type        desc
);

   logic [7:0]                 pos_ff, pos_in;
   logic [tsp_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [3:0]                 cc_ff [tsp_pkg::COUNTER_SLOTS];
   logic [tsp_pkg::SLOT_W-1:0] slot_use;
   logic                       open;
   logic                       opening;
   logic [7:0]                 pos_base;
   logic [7:0]                 pos_new;
   logic                       full_pkt;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;
   assign open      = (pos_ff != 8'd0);
   assign opening   = !open && req_first_of_section;
   assign slot_use  = opening ? req_counter_slot[tsp_pkg::SLOT_W-1:0] : slot_ff;
   assign pos_base  = open ? pos_ff : {7'd0, opening};
   assign pos_new   = pos_base + 8'd1;
   assign full_pkt  = (pos_new >= tsp_pkg::PAYLOAD_BYTES);

   always_comb begin
      desc.hdr   = !open;
      desc.start = opening;
      desc.ptr   = opening;
      desc.cc    = cc_ff[slot_use];
      desc.data  = req_section_byte;
      desc.eop   = full_pkt;
      desc.pad   = !full_pkt && req_last_of_section;
      desc.rep   = tsp_pkg::PAYLOAD_BYTES - pos_new;
      pos_in     = (full_pkt || req_last_of_section) ? 8'd0 : pos_new;
      slot_in    = slot_use;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         slot_ff <= '0;
         for (int i = 0; i < tsp_pkg::COUNTER_SLOTS; i++) begin
            cc_ff[i] <= '0;
         end
      end else if (push) begin
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
         if (!open) begin
            cc_ff[slot_use] <= desc.cc + 4'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsp_queue.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer descriptor queue
// A short queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tsp_pkg::desc_type push_desc,
   input  wire logic              pop,
   output tsp_pkg::desc_type      head,
   output tsp_pkg::qstat_type     qstat
);

   tsp_pkg::desc_type          mem_ff [tsp_pkg::QUEUE_DEPTH];
   logic [tsp_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tsp_pkg::QCNT_W-1:0] count_ff;
   logic                       do_push, do_pop;

   assign qstat.full  = (count_ff == tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsp_back.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer back part
// Steps through each descriptor, emitting header, pointer, data and padding
// results into the output register, one per cycle unless the result channel stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tsp_pkg::cfg_type   cfg,
   input  wire tsp_pkg::desc_type  head,
   input  wire tsp_pkg::qstat_type qstat,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic [7:0]              rsp_repeat_count,
   output logic                    rsp_end_of_packet,
   output logic                    rsp_end_of_run
);

   typedef enum logic [7:0] {
      ST_START = 8'b0000_0001,
      ST_SYNC  = 8'b0000_0010,
      ST_PIDHI = 8'b0000_0100,
      ST_PIDLO = 8'b0000_1000,
      ST_CC    = 8'b0001_0000,
      ST_PTR   = 8'b0010_0000,
      ST_DATA  = 8'b0100_0000,
      ST_PAD   = 8'b1000_0000
   } step_type;

   step_type   step_ff, step_in, cur, nxt;
   logic       load_ok, fire, last;
   logic [7:0] byte_c, rep_c;
   logic       eop_c;
   logic       valid_ff;
   logic [7:0] byte_ff, rep_ff;
   logic       eop_ff, eor_ff;

   assign load_ok = !valid_ff || !rsp_stall;
   assign fire    = load_ok && !qstat.empty;
   assign pop     = fire && last;

   always_comb begin
      if (step_ff == ST_START) begin
         cur = head.hdr ? ST_SYNC : ST_DATA;
      end else begin
         cur = step_ff;
      end
      byte_c = tsp_pkg::SYNC_BYTE;
      rep_c  = 8'd1;
      eop_c  = 1'b0;
      last   = 1'b0;
      nxt    = ST_START;
      unique case (cur)
         ST_SYNC: begin
            nxt = ST_PIDHI;
         end
         ST_PIDHI: begin
            byte_c = {1'b0, head.start, cfg.priority_bit, cfg.packet_id[12:8]};
            nxt    = ST_PIDLO;
         end
         ST_PIDLO: begin
            byte_c = cfg.packet_id[7:0];
            nxt    = ST_CC;
         end
         ST_CC: begin
            byte_c = {tsp_pkg::SCRAMBLE_BITS, cfg.field_control, head.cc};
            nxt    = head.ptr ? ST_PTR : ST_DATA;
         end
         ST_PTR: begin
            byte_c = tsp_pkg::POINTER_BYTE;
            nxt    = ST_DATA;
         end
         ST_DATA: begin
            byte_c = head.data;
            eop_c  = head.eop;
            last   = !head.pad;
            nxt    = head.pad ? ST_PAD : ST_START;
         end
         ST_PAD: begin
            byte_c = tsp_pkg::PAD_BYTE;
            rep_c  = head.rep;
            eop_c  = 1'b1;
            last   = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase
      step_in = last ? ST_START : nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_START;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            step_ff <= step_in;
         end
         if (load_ok) begin
            valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_c;
         rep_ff  <= rep_c;
         eop_ff  <= eop_c;
         eor_ff  <= last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_repeat_count  = rep_ff;
   assign rsp_end_of_packet = eop_ff;
   assign rsp_end_of_run    = eor_ff;

endmodule

`default_nettype wire

// ===== rtl/ts_section_packetizer_top.sv =====
// The first result of a transaction passes through the descriptor queue and the output register.
// The back part emits one result per cycle while the result channel is not stalled; a
// transaction has one result for a plain payload byte and up to seven at a packet start.
// A four-entry descriptor queue lets the input keep running while results are stalled.
// Reset is synchronous and active high; it clears the counters, position and queue.
// ----------------------------------------------------------------------------
// Transport stream section packetizer
// Carries section bytes in 188-byte transport packets with headers, pointer
// byte and padding.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_section_packetizer_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [3:0]                 req_counter_slot,
   input  wire logic [7:0]                 req_section_byte,
   input  wire logic                       req_first_of_section,
   input  wire logic                       req_last_of_section,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic [7:0]                      rsp_repeat_count,
   output logic                            rsp_end_of_packet,
   output logic                            rsp_end_of_run,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [tsp_pkg::ADDR_W-1:0] paddr,
   input  wire logic [tsp_pkg::DATA_W-1:0] pwdata,
   output logic      [tsp_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);

   tsp_pkg::cfg_type   cfg;
   tsp_pkg::desc_type  push_desc, head;
   tsp_pkg::qstat_type qstat;
   logic               push, pop;

   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsp_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_counter_slot     (req_counter_slot),
      .req_section_byte     (req_section_byte),
      .req_first_of_section (req_first_of_section),
      .req_last_of_section  (req_last_of_section),
      .qstat                (qstat),
      .push                 (push),
      .desc                 (push_desc)
   );

   tsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   tsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head              (head),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_end_of_run    (rsp_end_of_run)
   );

endmodule

`default_nettype wire

// ===== rtl/tsp_checker.sv =====
// ----------------------------------------------------------------------------
// Transport stream section packetizer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [7:0] rsp_repeat_count,
   input wire logic       rsp_end_of_packet,
   input wire logic       rsp_end_of_run
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_repeat_count) && $stable(rsp_end_of_packet)
         && $stable(rsp_end_of_run))
      else $error("stalled result transaction changed");

   a_pad_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_count != 8'd1 |-> rsp_out_byte == 8'hFF
         && rsp_end_of_packet && rsp_end_of_run)
      else $error("repeated result is not closing padding");

   a_rep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd184)
      else $error("repeat count out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ts_section_packetizer_top tsp_checker u_tsp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_repeat_count  (rsp_repeat_count),
   .rsp_end_of_packet (rsp_end_of_packet),
   .rsp_end_of_run    (rsp_end_of_run)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Section packetizer testbench
// Sends section bytes and checks the transport stream bytes that come back
// against a predictor held in the bench. Register writes are checked by
// reading them back. The request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] repeat_count;
      logic       end_of_packet;
      logic       end_of_run;
   } stream_byte_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [3:0]                  req_counter_slot = 4'd0;
   logic [7:0]                  req_section_byte = 8'd0;
   logic                        req_first_of_section = 1'b0;
   logic                        req_last_of_section = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [7:0]                  rsp_out_byte;
   logic [7:0]                  rsp_repeat_count;
   logic                        rsp_end_of_packet;
   logic                        rsp_end_of_run;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [tsp_pkg::ADDR_W-1:0]  paddr = '0;
   logic [tsp_pkg::DATA_W-1:0]  pwdata = '0;
   logic [tsp_pkg::DATA_W-1:0]  prdata;
   logic                        pready;

   stream_byte_type             expected_bytes[$];
   logic [3:0]                  continuity[tsp_pkg::COUNTER_SLOTS];
   logic [7:0]                  fill_level;
   logic [3:0]                  open_slot;
   logic [12:0]                 pid_reg;
   logic                        prio_reg;
   logic [1:0]                  afc_reg;

   int                          mismatch_count = 0;
   int                          items_sent = 0;
   int                          random_start = 0;
   bit                          idle_enable = 1'b1;
   bit                          stall_enable = 1'b1;

   ts_section_packetizer_top uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_counter_slot     (req_counter_slot),
      .req_section_byte     (req_section_byte),
      .req_first_of_section (req_first_of_section),
      .req_last_of_section  (req_last_of_section),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_repeat_count     (rsp_repeat_count),
      .rsp_end_of_packet    (rsp_end_of_packet),
      .rsp_end_of_run       (rsp_end_of_run),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= stall_enable && ($urandom_range(99) < 18);
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic stream_byte_type ts_byte(input logic [7:0] value,
                                               input logic [7:0] reps, input logic eop);
      stream_byte_type r;
      r.out_byte      = value;
      r.repeat_count  = reps;
      r.end_of_packet = eop;
      r.end_of_run    = 1'b0;
      return r;
   endfunction

   function automatic void clear_packetizer();
      for (int i = 0; i < tsp_pkg::COUNTER_SLOTS; i++) continuity[i] = 4'd0;
      fill_level = 8'd0;
      open_slot  = 4'd0;
      pid_reg    = tsp_pkg::PACKET_ID_RESET;
      prio_reg   = tsp_pkg::PRIORITY_BIT_RESET;
      afc_reg    = tsp_pkg::FIELD_CONTROL_RESET;
   endfunction

   // Works out the stream bytes that one accepted section byte produces.
   function automatic void packetize_byte(input logic [3:0] slot, input logic [7:0] data,
                                          input logic opening, input logic closing);
      stream_byte_type run[7];
      int              n;
      logic [3:0]      cc;
      n = 0;
      if (fill_level == 8'd0) begin
         if (opening) open_slot = slot;
         cc = continuity[open_slot];
         continuity[open_slot] = cc + 4'd1;
         run[0] = ts_byte(tsp_pkg::SYNC_BYTE, 8'd1, 1'b0);
         run[1] = ts_byte({1'b0, opening, prio_reg, pid_reg[12:8]}, 8'd1, 1'b0);
         run[2] = ts_byte(pid_reg[7:0], 8'd1, 1'b0);
         run[3] = ts_byte({tsp_pkg::SCRAMBLE_BITS, afc_reg, cc}, 8'd1, 1'b0);
         n = 4;
         if (opening) begin
            run[4] = ts_byte(tsp_pkg::POINTER_BYTE, 8'd1, 1'b0);
            n = 5;
            fill_level = 8'd1;
         end
      end
      fill_level = fill_level + 8'd1;
      if (fill_level >= tsp_pkg::PAYLOAD_BYTES) begin
         run[n] = ts_byte(data, 8'd1, 1'b1);
         n++;
         fill_level = 8'd0;
      end else begin
         run[n] = ts_byte(data, 8'd1, 1'b0);
         n++;
         if (closing) begin
            run[n] = ts_byte(tsp_pkg::PAD_BYTE, tsp_pkg::PAYLOAD_BYTES - fill_level,
                             1'b1);
            n++;
            fill_level = 8'd0;
         end
      end
      run[n - 1].end_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_bytes.insert(expected_bytes.size(), run[i]);
   endfunction

   function automatic logic [tsp_pkg::DATA_W-1:0] register_value(input logic [1:0] code);
      case (code)
         tsp_pkg::REG_PACKET_ID:     return tsp_pkg::DATA_W'(pid_reg);
         tsp_pkg::REG_PRIORITY_BIT:  return tsp_pkg::DATA_W'(prio_reg);
         tsp_pkg::REG_FIELD_CONTROL: return tsp_pkg::DATA_W'(afc_reg);
         default:                    return '0;
      endcase
   endfunction

   task automatic csr_write(input logic [1:0] code, input logic [tsp_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {code, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (code)
         tsp_pkg::REG_PACKET_ID:     pid_reg  = value[12:0];
         tsp_pkg::REG_PRIORITY_BIT:  prio_reg = value[0];
         tsp_pkg::REG_FIELD_CONTROL: afc_reg  = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_register(input logic [1:0] code);
      logic [tsp_pkg::DATA_W-1:0] value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {code, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (value !== register_value(code))
         report_mismatch($sformatf("register %0d reads %0h, wrote %0h", code, value,
                                   register_value(code)));
   endtask

   task automatic send_byte(input logic [3:0] slot, input logic [7:0] data,
                            input logic opening, input logic closing);
      while (idle_enable && $urandom_range(99) < 18) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_counter_slot     <= slot;
      req_section_byte     <= data;
      req_first_of_section <= opening;
      req_last_of_section  <= closing;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      packetize_byte(slot, data, opening, closing);
      items_sent++;
   endtask

   // Stray first marks are ignored while a packet is open, not at a packet boundary.
   task automatic send_section(input logic [3:0] slot, input int length, input bit closed);
      logic       opening;
      logic [3:0] s;
      for (int i = 0; i < length; i++) begin
         opening = (i == 0) || ($urandom_range(99) < 4);
         s = (i == 0) ? slot : 4'($urandom_range(15));
         send_byte(s, 8'($urandom_range(255)), opening, closed && (i == length - 1));
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_slot();
      if ($urandom_range(1) == 0) return 4'($urandom_range(1));
      return 4'($urandom_range(15));
   endfunction

   always @(posedge clock) begin : check_results
      stream_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.out_byte));
            if (rsp_repeat_count !== want.repeat_count)
               report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                         rsp_repeat_count, want.repeat_count));
            if (rsp_end_of_packet !== want.end_of_packet)
               report_mismatch($sformatf("end_of_packet %b, expected %b",
                                         rsp_end_of_packet, want.end_of_packet));
            if (rsp_end_of_run !== want.end_of_run)
               report_mismatch($sformatf("end_of_run %b, expected %b",
                                         rsp_end_of_run, want.end_of_run));
         end
      end
   end

   task automatic test_registers();
      check_register(tsp_pkg::REG_PACKET_ID);
      check_register(tsp_pkg::REG_PRIORITY_BIT);
      check_register(tsp_pkg::REG_FIELD_CONTROL);
      csr_write(tsp_pkg::REG_PACKET_ID, 32'h1FFF);
      csr_write(tsp_pkg::REG_PRIORITY_BIT, 32'h1);
      csr_write(tsp_pkg::REG_FIELD_CONTROL, 32'h3);
      check_register(tsp_pkg::REG_PACKET_ID);
      check_register(tsp_pkg::REG_PRIORITY_BIT);
      check_register(tsp_pkg::REG_FIELD_CONTROL);
      csr_write(tsp_pkg::REG_PACKET_ID, 32'h0);
      csr_write(tsp_pkg::REG_PRIORITY_BIT, 32'h0);
      csr_write(tsp_pkg::REG_FIELD_CONTROL, 32'h1);
      check_register(tsp_pkg::REG_PACKET_ID);
   endtask

   task automatic test_directed();
      // A byte with no first mark straight after reset opens a continuation packet.
      send_byte(4'hF, 8'hA5, 1'b0, 1'b1);
      send_byte(4'hF, 8'h00, 1'b1, 1'b1);
      send_byte(4'hF, 8'hFF, 1'b1, 1'b0);
      send_byte(4'h3, 8'h5A, 1'b1, 1'b0);
      send_byte(4'h0, 8'h81, 1'b0, 1'b1);
      wait_for_drain();
      csr_write(tsp_pkg::REG_PACKET_ID, 32'h1FFF);
      csr_write(tsp_pkg::REG_PRIORITY_BIT, 32'h1);
      csr_write(tsp_pkg::REG_FIELD_CONTROL, 32'h3);
      send_byte(4'h0, 8'h7E, 1'b1, 1'b0);
      send_byte(4'h0, 8'h01, 1'b0, 1'b1);
      wait_for_drain();
      csr_write(tsp_pkg::REG_PACKET_ID, 32'h1555);
      csr_write(tsp_pkg::REG_PRIORITY_BIT, 32'h0);
      csr_write(tsp_pkg::REG_FIELD_CONTROL, 32'h0);
      send_byte(4'h7, 8'hC3, 1'b1, 1'b1);
      wait_for_drain();
      csr_write(tsp_pkg::REG_PACKET_ID, 32'h0AAA);
      csr_write(tsp_pkg::REG_FIELD_CONTROL, 32'h2);
      send_byte(4'h9, 8'h3C, 1'b0, 1'b1);
      send_byte(4'h8, 8'h55, 1'b1, 1'b0);
      send_byte(4'h8, 8'hAA, 1'b0, 1'b0);
      send_byte(4'h2, 8'h10, 1'b1, 1'b0);
      send_byte(4'h2, 8'hEF, 1'b0, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_packet_fill();
      csr_write(tsp_pkg::REG_PACKET_ID, $urandom_range(8191));
      csr_write(tsp_pkg::REG_PRIORITY_BIT, $urandom_range(1));
      csr_write(tsp_pkg::REG_FIELD_CONTROL,
                tsp_pkg::DATA_W'(tsp_pkg::FIELD_CONTROL_RESET));
      // The closing byte lands exactly on the last payload position.
      send_section(pick_slot(), 183, 1'b1);
      idle_enable  = 1'b0;
      stall_enable = 1'b0;
      send_section(pick_slot(), 186, 1'b1);
      idle_enable  = 1'b1;
      stall_enable = 1'b1;
      wait_for_drain();
   endtask

   task automatic test_counter_wrap();
      logic [3:0] slot;
      slot = 4'($urandom_range(15));
      for (int i = 0; i < 17; i++) send_section(slot, $urandom_range(1, 2), 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_sections();
      int kind;
      while (items_sent - random_start < 460) begin
         kind = $urandom_range(99);
         if (kind < 15)
            send_byte(4'($urandom_range(15)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         else if (kind < 25)
            send_section(pick_slot(), $urandom_range(1, 12), 1'b0);
         else if (kind < 85)
            send_section(pick_slot(), $urandom_range(1, 12), 1'b1);
         else
            send_section(pick_slot(), $urandom_range(13, 60), 1'b1);
         if ($urandom_range(99) < 12) begin
            wait_for_drain();
            case ($urandom_range(2))
               0:       csr_write(tsp_pkg::REG_PACKET_ID, $urandom_range(8191));
               1:       csr_write(tsp_pkg::REG_PRIORITY_BIT, $urandom_range(1));
               default: csr_write(tsp_pkg::REG_FIELD_CONTROL, $urandom_range(3));
            endcase
         end
      end
   endtask

   initial begin
      clear_packetizer();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_registers();
      random_start = items_sent;
      test_directed();
      test_packet_fill();
      test_counter_wrap();
      test_random_sections();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tsp_pkg.sv
rtl/tsp_csr.sv
rtl/tsp_front.sv
rtl/tsp_queue.sv
rtl/tsp_back.sv
rtl/ts_section_packetizer_top.sv
rtl/tsp_checker.sv
bench/testbench.sv
